// ----- hdl/xst_pkg.sv -----
// ----------------------------------------------------------------------------
// XML segment tokenizer package
// Shared types, segment kind codes and character constants for the UTF-16BE
// XML segment tokenizer.
// ----------------------------------------------------------------------------
package xst_pkg;

	// Byte positions wrap modulo the buffer size; 16 bits cover 65536 bytes.
	localparam int unsigned POS_W = 16;

	// Segment kind codes reported with each result.
	localparam logic [1:0] KIND_TAG     = 2'd0;
	localparam logic [1:0] KIND_CONTENT = 2'd1;
	localparam logic [1:0] KIND_COMMENT = 2'd2;
	localparam logic [1:0] KIND_CDATA   = 2'd3;

	// ASCII code units used by the openers and closers.
	localparam logic [15:0] CH_LT    = 16'h003C;
	localparam logic [15:0] CH_GT    = 16'h003E;
	localparam logic [15:0] CH_BANG  = 16'h0021;
	localparam logic [15:0] CH_DASH  = 16'h002D;
	localparam logic [15:0] CH_LBRK  = 16'h005B;
	localparam logic [15:0] CH_RBRK  = 16'h005D;

	// Number of code units in the "<![CDATA[" opener.
	localparam logic [3:0] CDATA_OPENER_LEN = 4'd9;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} item_t;

	typedef struct packed {
		logic [1:0]       segment_kind;
		logic [POS_W-1:0] segment_offset;
		logic [POS_W-1:0] segment_length;
	} result_t;

	// Lower-case pattern byte of the CDATA opener at a given index.
	function automatic logic [7:0] cdata_pattern(input logic [3:0] idx);
		logic [7:0] pat;
		begin
			unique case (idx)
				4'd0: pat = 8'h3C; // '<'
				4'd1: pat = 8'h21; // '!'
				4'd2: pat = 8'h5B; // '['
				4'd3: pat = 8'h63; // 'c'
				4'd4: pat = 8'h64; // 'd'
				4'd5: pat = 8'h61; // 'a'
				4'd6: pat = 8'h74; // 't'
				4'd7: pat = 8'h61; // 'a'
				4'd8: pat = 8'h5B; // '['
				default: pat = 8'h00;
			endcase
			return pat;
		end
	endfunction

	// A code unit matches the CDATA opener at idx when it is a single byte
	// equal to the pattern letter after ASCII lower-casing.
	function automatic logic cdata_match(input logic [15:0] u, input logic [3:0] idx);
		logic [7:0] lo;
		begin
			lo = u[7:0];
			if (lo >= 8'h41 && lo <= 8'h5A) begin
				lo = lo + 8'h20;
			end
			return (idx <= 4'd8) && (u[15:8] == 8'h00) && (lo == cdata_pattern(idx));
		end
	endfunction

endpackage

// ----- hdl/xml_segment_tokenizer_utf16_top.sv -----
// ----------------------------------------------------------------------------
// XML segment tokenizer, UTF-16 big-endian
// Splits a stream of UTF-16BE code units into tag, content, comment and CDATA
// segments and reports each closed segment with its byte offset and length.
// ----------------------------------------------------------------------------
// The block takes one code unit per transfer on the item channel and can
// accept a new code unit in every clock cycle while the result channel does
// not stall. Each code unit is captured in an input register, classified by
// a small amount of logic against the parse state, and any segment it closes
// is loaded into the result register, from which the result leaves. The
// sustained rate is one code unit per cycle without result stalls; it is set
// by the single update of the parse state per code unit. A code unit
// produces at most one result. A stall on the result channel while the
// result register is full holds that register and, in the same cycle, the
// input register when it holds a code unit; the item channel then stalls
// until the waiting result transfers. Offsets and lengths count bytes, two
// per code unit, modulo 65536. A code unit with last_unit set returns the
// parser to its reset state after it is handled; a segment still open at
// that point is not reported.
// ----------------------------------------------------------------------------
module xml_segment_tokenizer_utf16_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  xst_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output xst_pkg::result_t result
);

	// Parse modes.
	localparam logic [2:0] M_BEFORE   = 3'd0;
	localparam logic [2:0] M_TAG      = 3'd1;
	localparam logic [2:0] M_CONTENT  = 3'd2;
	localparam logic [2:0] M_COMMENT  = 3'd3;
	localparam logic [2:0] M_CDATA    = 3'd4;
	localparam logic [2:0] M_OPEN     = 3'd5;
	localparam logic [2:0] M_OPEN_COM = 3'd6;
	localparam logic [2:0] M_OPEN_CD  = 3'd7;

	// Input register.
	logic           s1_valid_q;
	xst_pkg::item_t item_s1;

	// Parse state.
	logic [2:0]                  mode_q;
	logic [3:0]                  prog_q;
	logic [1:0]                  run_q;
	logic [xst_pkg::POS_W-1:0]   start_q;
	logic [xst_pkg::POS_W-1:0]   pos_q;

	// Result register.
	logic             out_valid_q;
	xst_pkg::result_t out_q;

	logic out_ready;
	logic proc;

	// Next-state and result of the code unit in the input register.
	logic [2:0]                mode_d;
	logic [3:0]                prog_d;
	logic [1:0]                run_d;
	logic [xst_pkg::POS_W-1:0] start_d;
	logic [xst_pkg::POS_W-1:0] next_pos;
	logic                      emit;
	logic [1:0]                emit_kind;
	logic [xst_pkg::POS_W-1:0] emit_end;
	logic                      as_tag;
	logic [15:0]               u;
	logic [15:0]               run_ch;

	// The result register can load when it is empty or being drained this
	// cycle; the input register advances under the same condition or when empty.
	assign out_ready  = !out_valid_q || !result_stall;
	assign proc       = s1_valid_q && out_ready;
	assign item_stall = s1_valid_q && !out_ready;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		u         = item_s1.code_unit;
		next_pos  = pos_q + xst_pkg::POS_W'(2);
		mode_d    = mode_q;
		prog_d    = prog_q;
		run_d     = run_q;
		start_d   = start_q;
		emit      = 1'b0;
		emit_kind = xst_pkg::KIND_TAG;
		emit_end  = pos_q;
		as_tag    = 1'b0;
		run_ch    = (mode_q == M_COMMENT) ? xst_pkg::CH_DASH : xst_pkg::CH_RBRK;

		unique case (mode_q)
			M_TAG: begin
				as_tag = 1'b1;
			end
			M_CONTENT: begin
				if (u == xst_pkg::CH_LT) begin
					emit      = 1'b1;
					emit_kind = xst_pkg::KIND_CONTENT;
					start_d   = next_pos;
					mode_d    = M_OPEN;
					prog_d    = 4'd1;
				end
			end
			M_OPEN: begin
				priority if (prog_q == 4'd1 && u == xst_pkg::CH_BANG) begin
					prog_d = 4'd2;
				end else if (prog_q == 4'd2 && u == xst_pkg::CH_DASH) begin
					prog_d = 4'd3;
					mode_d = M_OPEN_COM;
				end else if (prog_q == 4'd2 && u == xst_pkg::CH_LBRK) begin
					prog_d = 4'd3;
					mode_d = M_OPEN_CD;
				end else begin
					as_tag = 1'b1;
				end
			end
			M_OPEN_COM: begin
				if (u == xst_pkg::CH_DASH) begin
					mode_d  = M_COMMENT;
					prog_d  = 4'd0;
					run_d   = 2'd0;
					start_d = next_pos;
				end else begin
					as_tag = 1'b1;
				end
			end
			M_OPEN_CD: begin
				if (xst_pkg::cdata_match(u, prog_q)) begin
					prog_d = prog_q + 4'd1;
					if (prog_d >= xst_pkg::CDATA_OPENER_LEN) begin
						mode_d  = M_CDATA;
						prog_d  = 4'd0;
						run_d   = 2'd0;
						start_d = next_pos;
					end
				end else begin
					as_tag = 1'b1;
				end
			end
			M_COMMENT, M_CDATA: begin
				priority if (u == run_ch) begin
					if (run_q < 2'd2) begin
						run_d = run_q + 2'd1;
					end
				end else if (u == xst_pkg::CH_GT && run_q == 2'd2) begin
					// The closer's two leading units are not part of the segment.
					emit      = 1'b1;
					emit_kind = (mode_q == M_COMMENT) ? xst_pkg::KIND_COMMENT
						: xst_pkg::KIND_CDATA;
					emit_end  = pos_q - xst_pkg::POS_W'(4);
					start_d   = next_pos;
					mode_d    = M_CONTENT;
					run_d     = 2'd0;
				end else begin
					run_d = 2'd0;
				end
			end
			default: begin
				if (u == xst_pkg::CH_LT) begin
					start_d = next_pos;
					mode_d  = M_TAG;
				end
			end
		endcase

		// A tag unit, or an opener that failed to match, continues as a tag.
		if (as_tag) begin
			mode_d = M_TAG;
			prog_d = 4'd0;
			if (u == xst_pkg::CH_GT) begin
				emit      = 1'b1;
				emit_kind = xst_pkg::KIND_TAG;
				emit_end  = pos_q;
				start_d   = next_pos;
				mode_d    = M_CONTENT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!item_stall) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_BEFORE;
			prog_q  <= 4'd0;
			run_q   <= 2'd0;
			start_q <= '0;
			pos_q   <= '0;
		end else if (proc) begin
			if (item_s1.last_unit) begin
				mode_q  <= M_BEFORE;
				prog_q  <= 4'd0;
				run_q   <= 2'd0;
				start_q <= '0;
				pos_q   <= '0;
			end else begin
				mode_q  <= mode_d;
				prog_q  <= prog_d;
				run_q   <= run_d;
				start_q <= start_d;
				pos_q   <= next_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= proc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_q.segment_kind   <= emit_kind;
			out_q.segment_offset <= start_q;
			out_q.segment_length <= emit_end - start_q;
		end
	end

	// The segment start only moves once a first '<' has been seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_BEFORE) |-> (start_q == '0))
		else $error("segment start moved before the first tag");

	// A last unit returns the parser to its reset state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && item_s1.last_unit) |=> (mode_q == M_BEFORE && pos_q == '0 && run_q == 2'd0))
		else $error("parser not reset after last unit");

	// Every other handled unit advances the byte position by two.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !item_s1.last_unit) |=> (pos_q == $past(pos_q) + xst_pkg::POS_W'(2)))
		else $error("byte position did not advance by one code unit");

	// Opener progress never passes the CDATA opener length.
	assert property (@(posedge clk) disable iff (!arst_n)
		prog_q < xst_pkg::CDATA_OPENER_LEN)
		else $error("opener progress out of range");

	// A result is loaded only from a handled unit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready && !proc) |=> !out_valid_q)
		else $error("result appeared without a handled code unit");

endmodule

// ----- tb/sv/xst_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// XML segment tokenizer scoreboard
// Predicts the segments that each accepted code unit closes and checks the
// segments that leave the block against them, oldest first.
// ----------------------------------------------------------------------------
package xst_tb_pkg;

	import xst_pkg::*;

	typedef enum logic [2:0] {
		MODE_BEFORE,
		MODE_TAG,
		MODE_CONTENT,
		MODE_COMMENT,
		MODE_CDATA,
		MODE_OPEN,
		MODE_OPEN_COMMENT,
		MODE_OPEN_CDATA
	} parse_mode_e;

	// Lower-case spelling of the CDATA opener, one byte per code unit.
	localparam string CDATA_OPENER = "<![cdata[";

	class segment_scoreboard;

		parse_mode_e      mode;
		logic [3:0]       opener_cnt;
		logic [1:0]       closer_cnt;
		logic [POS_W-1:0] seg_start;
		logic [POS_W-1:0] byte_pos;

		result_t     expected_segments[$];
		int unsigned mismatches;
		int unsigned segments_checked;
		int unsigned kind_seen[4];

		function new();
			restart();
			mismatches = 0;
			segments_checked = 0;
			foreach (kind_seen[k]) kind_seen[k] = 0;
		endfunction

		function void restart();
			mode = MODE_BEFORE;
			opener_cnt = '0;
			closer_cnt = '0;
			seg_start = '0;
			byte_pos = '0;
		endfunction

		// The open segment ends just before byte end_pos; positions wrap at 16 bits.
		function void close_segment(logic [1:0] kind, logic [POS_W-1:0] end_pos);
			result_t seg;
			seg.segment_kind = kind;
			seg.segment_offset = seg_start;
			seg.segment_length = end_pos - seg_start;
			expected_segments.push_back(seg);
		endfunction

		function void note_code_unit(item_t it);
			logic [15:0]      u;
			logic [POS_W-1:0] pos;
			logic [POS_W-1:0] nxt;
			logic [15:0]      closer;
			logic [7:0]       lo;
			bit               as_tag;
			u = it.code_unit;
			pos = byte_pos;
			nxt = byte_pos + 16'd2;
			as_tag = 1'b0;
			case (mode)
				MODE_TAG: begin
					as_tag = 1'b1;
				end
				MODE_CONTENT: begin
					if (u == CH_LT) begin
						close_segment(KIND_CONTENT, pos);
						seg_start = nxt;
						mode = MODE_OPEN;
						opener_cnt = 4'd1;
					end
				end
				MODE_OPEN: begin
					if (opener_cnt == 4'd1 && u == CH_BANG) begin
						opener_cnt = 4'd2;
					end else if (opener_cnt == 4'd2 && u == CH_DASH) begin
						opener_cnt = 4'd3;
						mode = MODE_OPEN_COMMENT;
					end else if (opener_cnt == 4'd2 && u == CH_LBRK) begin
						opener_cnt = 4'd3;
						mode = MODE_OPEN_CDATA;
					end else begin
						as_tag = 1'b1;
					end
				end
				MODE_OPEN_COMMENT: begin
					if (u == CH_DASH) begin
						mode = MODE_COMMENT;
						opener_cnt = '0;
						closer_cnt = '0;
						seg_start = nxt;
					end else begin
						as_tag = 1'b1;
					end
				end
				MODE_OPEN_CDATA: begin
					lo = u[7:0];
					if (lo >= 8'h41 && lo <= 8'h5A) begin
						lo = lo + 8'h20;
					end
					if (opener_cnt <= 4'd8 && u[15:8] == 8'h00 &&
					    lo == 8'(CDATA_OPENER[opener_cnt])) begin
						opener_cnt = opener_cnt + 4'd1;
						if (opener_cnt >= CDATA_OPENER_LEN) begin
							mode = MODE_CDATA;
							opener_cnt = '0;
							closer_cnt = '0;
							seg_start = nxt;
						end
					end else begin
						as_tag = 1'b1;
					end
				end
				MODE_COMMENT, MODE_CDATA: begin
					closer = (mode == MODE_COMMENT) ? CH_DASH : CH_RBRK;
					if (u == closer) begin
						if (closer_cnt < 2'd2) begin
							closer_cnt = closer_cnt + 2'd1;
						end
					end else if (u == CH_GT && closer_cnt == 2'd2) begin
						// The two closer units before the '>' are not part of the body.
						close_segment((mode == MODE_COMMENT) ? KIND_COMMENT : KIND_CDATA,
							pos - 16'd4);
						seg_start = nxt;
						mode = MODE_CONTENT;
						closer_cnt = '0;
					end else begin
						closer_cnt = '0;
					end
				end
				default: begin
					if (u == CH_LT) begin
						seg_start = nxt;
						mode = MODE_TAG;
					end
				end
			endcase
			if (as_tag) begin
				mode = MODE_TAG;
				opener_cnt = '0;
				if (u == CH_GT) begin
					close_segment(KIND_TAG, pos);
					seg_start = nxt;
					mode = MODE_CONTENT;
				end
			end
			byte_pos = nxt;
			if (it.last_unit) begin
				restart();
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t ns: %s", $time, msg);
			mismatches++;
		endtask

		task check_segment(result_t got);
			result_t want;
			if (expected_segments.size() == 0) begin
				report($sformatf("segment kind %0d offset %0d length %0d with none pending",
					got.segment_kind, got.segment_offset, got.segment_length));
			end else begin
				want = expected_segments.pop_front();
				segments_checked++;
				kind_seen[want.segment_kind]++;
				if (got.segment_kind !== want.segment_kind) begin
					report($sformatf("segment_kind got %0d want %0d",
						got.segment_kind, want.segment_kind));
				end
				if (got.segment_offset !== want.segment_offset) begin
					report($sformatf("segment_offset got %0d want %0d",
						got.segment_offset, want.segment_offset));
				end
				if (got.segment_length !== want.segment_length) begin
					report($sformatf("segment_length got %0d want %0d",
						got.segment_length, want.segment_length));
				end
			end
		endtask

		function int unsigned pending();
			return expected_segments.size();
		endfunction

	endclass

endpackage

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// XML segment tokenizer testbench
// Feeds UTF-16BE code units through the item channel and checks every
// reported segment against a scoreboard that tracks the parse state itself.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import xst_pkg::*;
	import xst_tb_pkg::*;

	// Number of random code units after the short directed phase.
	localparam int unsigned ITEM_TARGET = 1520;
	// Length of the one long hold-off on the result channel.
	localparam int unsigned HOLDOFF_CYCLES = 300;
	// Cycles without any transfer before the run is declared hung.
	localparam int unsigned WATCHDOG_LIMIT = 3000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	segment_scoreboard sb;

	// Idling on each side can be switched off for the last part of the run.
	bit          send_idling;
	bit          recv_idling;
	// Set by the stimulus, taken and cleared by the receiver process.
	bit          holdoff_req;
	int unsigned sent_units;
	int unsigned idle_cycles;

	xml_segment_tokenizer_utf16_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// All transfers are observed at the rising edge. A result at this edge
	// always belongs to a code unit accepted earlier, so the order of the
	// two checks inside this block does not matter for the prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				sb.check_segment(result);
			end
			if (item_valid && !item_stall) begin
				sb.note_code_unit(item);
			end
		end
	end

	// The receiver drives result_stall at each falling edge. Short random
	// bursts model a busy consumer; a hold-off request stalls it for a long
	// stretch so that the block fills up and stalls its own input.
	initial begin
		int unsigned stall_left;
		result_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				stall_left = HOLDOFF_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (recv_idling && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// The watchdog ends a hung run: it counts cycles in which neither
	// channel completes a transfer.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Offers one code unit and returns at the rising edge of its transfer.
	// A random gap may come first; valid is lowered and raised again at
	// different falling edges, and a stalled payload is left alone.
	task automatic send_unit(input logic [15:0] u, input logic last);
		int unsigned gap;
		@(negedge clk);
		if (send_idling && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 19);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{code_unit: u, last_unit: last};
		do @(posedge clk); while (item_stall);
		sent_units++;
	endtask

	// Sends an ASCII string, one code unit per character.
	task automatic send_text(input string s, input bit last);
		for (int i = 0; i < s.len(); i++) begin
			send_unit(16'(s[i]), last && (i == s.len() - 1));
		end
	endtask

	// Stops offering until every predicted segment has come out.
	task automatic drain_pause();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// A body unit leans toward letters and the characters that drive the
	// openers and closers, with some arbitrary 16-bit code units mixed in.
	function automatic logic [15:0] body_unit();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'(16'h0061 + $urandom_range(0, 25));
			4:          return CH_DASH;
			5:          return CH_RBRK;
			6:          return CH_GT;
			7:          return $urandom_range(0, 1) ? CH_BANG : CH_LBRK;
			8:          return 16'(16'h0041 + $urandom_range(0, 25));
			default:    return 16'($urandom);
		endcase
	endfunction

	// Builds one document piece and sends it. Most pieces are well formed
	// tags, content, comments and CDATA sections; the rest are openers that
	// break off part way and plain noise. With end_doc the final unit of
	// the piece carries last_unit and the parser starts over after it.
	task automatic send_token(input bit end_doc);
		logic [15:0] units[$];
		string       kw;
		int unsigned n;
		int unsigned good;
		logic [15:0] letter;
		kw = "cdata";
		case ($urandom_range(0, 11))
			0, 1, 2: begin
				units.push_back(CH_LT);
				n = $urandom_range(0, 4);
				repeat (n) units.push_back(body_unit());
				units.push_back(CH_GT);
			end
			3, 4: begin
				n = $urandom_range(0, 6);
				repeat (n) units.push_back(body_unit());
			end
			5, 6: begin
				units.push_back(CH_LT);
				units.push_back(CH_BANG);
				units.push_back(CH_DASH);
				units.push_back(CH_DASH);
				n = $urandom_range(0, 6);
				repeat (n) units.push_back(body_unit());
				// A closer run of more than two dashes still closes at the '>'.
				n = $urandom_range(2, 4);
				repeat (n) units.push_back(CH_DASH);
				units.push_back(CH_GT);
			end
			7, 8: begin
				units.push_back(CH_LT);
				units.push_back(CH_BANG);
				units.push_back(CH_LBRK);
				for (int i = 0; i < 5; i++) begin
					letter = 16'(kw[i]);
					if ($urandom_range(0, 1)) letter = letter - 16'h0020;
					units.push_back(letter);
				end
				units.push_back(CH_LBRK);
				n = $urandom_range(0, 6);
				repeat (n) units.push_back(body_unit());
				n = $urandom_range(2, 4);
				repeat (n) units.push_back(CH_RBRK);
				units.push_back(CH_GT);
			end
			9: begin
				// Comment opener that goes wrong after '<!' or after '<!-'.
				units.push_back(CH_LT);
				units.push_back(CH_BANG);
				if ($urandom_range(0, 1)) units.push_back(CH_DASH);
				units.push_back($urandom_range(0, 1) ? CH_GT : body_unit());
				n = $urandom_range(0, 3);
				repeat (n) units.push_back(body_unit());
				units.push_back(CH_GT);
			end
			10: begin
				// CDATA opener that breaks off: a letter with a nonzero high
				// byte, a wrong letter, or an early '>'.
				units.push_back(CH_LT);
				units.push_back(CH_BANG);
				units.push_back(CH_LBRK);
				good = $urandom_range(0, 5);
				for (int i = 0; i < good; i++) begin
					units.push_back(i < 5 ? 16'(kw[i]) : CH_LBRK);
				end
				case ($urandom_range(0, 2))
					0:       units.push_back(16'h0100 |
						16'(good < 5 ? kw[good] : 8'h5B) | 16'(8'($urandom_range(0, 1)) << 8));
					1:       units.push_back(16'(16'h0061 + $urandom_range(0, 25)));
					default: units.push_back(CH_GT);
				endcase
				n = $urandom_range(0, 3);
				repeat (n) units.push_back(body_unit());
				units.push_back(CH_GT);
			end
			default: begin
				n = $urandom_range(1, 4);
				repeat (n) units.push_back(16'($urandom));
			end
		endcase
		if (units.size() == 0) begin
			units.push_back(body_unit());
		end
		foreach (units[i]) begin
			send_unit(units[i], end_doc && (i == units.size() - 1));
		end
	endtask

	initial begin
		int unsigned base;
		int unsigned done;
		bit          holdoff_done;
		bit          drain_done;

		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		send_idling = 1'b1;
		recv_idling = 1'b1;
		holdoff_req = 1'b0;
		sent_units = 0;
		holdoff_done = 1'b0;
		drain_done = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A unit before the first '<' is ignored, then an
		// empty tag.
		send_unit(16'hFFFF, 1'b0);
		send_text("<>", 1'b0);
		// Empty content, then a comment opener that fails on '>' and so
		// closes a tag starting right after the '<'.
		send_text("<!>", 1'b0);
		// A comment holding one dash, closed by an overlong dash run.
		send_text("<!----->", 1'b0);
		// A mixed-case CDATA opener and an overlong bracket run.
		send_text("<![CdAtA[]]]>", 1'b0);
		// The last unit opens a tag; that tag is dropped unreported.
		send_text("<", 1'b1);
		send_unit(16'h0000, 1'b0);

		// Random part. Along the way the receiver holds off once for a long
		// stretch and the sender waits once for a full drain; the last part
		// runs without idling on either side.
		base = sent_units;
		while (sent_units - base < ITEM_TARGET) begin
			done = sent_units - base;
			if (!holdoff_done && done >= 500) begin
				holdoff_req = 1'b1;
				holdoff_done = 1'b1;
			end
			if (!drain_done && done >= 900) begin
				drain_pause();
				drain_done = 1'b1;
			end
			if (done >= ITEM_TARGET - 250) begin
				send_idling = 1'b0;
				recv_idling = 1'b0;
			end
			send_token($urandom_range(0, 19) == 0);
		end
		@(negedge clk);
		item_valid <= 1'b0;

		// Wait for the last segments, then keep watching for anything the block
		// should not have produced.
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d code units, checked %0d segments: tag %0d, content %0d, %s",
			sent_units, sb.segments_checked, sb.kind_seen[KIND_TAG],
			sb.kind_seen[KIND_CONTENT],
			$sformatf("comment %0d, cdata %0d", sb.kind_seen[KIND_COMMENT],
				sb.kind_seen[KIND_CDATA]));
		$display("run included broken openers, overlong closers, a long result hold-off and a drain");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
